>>> rtl/cmr_pkg.sv
// shared types, constants and width helpers of the catmull-rom path subdivider
package cmr_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int MAX_STEPS_DEF  = 16;
  localparam int RESULT_CAP     = 32;
  localparam int STEP_LEN_BITS  = 16;
  localparam int DIST_LIMIT_BIT = 24;
  localparam logic [STEP_LEN_BITS-1:0] STEP_LEN_RESET = 16'd1024;

  function automatic int seg_limit(int max_steps);
    return (2 * max_steps <= RESULT_CAP) ? max_steps : (RESULT_CAP / 2);
  endfunction

  function automatic int step_bits(int max_steps);
    return $clog2(seg_limit(max_steps) + 1);
  endfunction

  function automatic int fac_bits(int max_steps);
    int s;
    s = seg_limit(max_steps);
    return $clog2(2 * s * s * s + 1);
  endfunction

  function automatic int num_bits(int coord_bits, int max_steps);
    return coord_bits + 4 + fac_bits(max_steps) + 1 + 3;
  endfunction

  typedef enum logic [4:0] {
    OP_NONE,
    OP_TAKE,
    OP_ECHO,
    OP_SEG_LINE,
    OP_SEG_A,
    OP_SEG_B,
    OP_DCLR,
    OP_DSQ,
    OP_DACC,
    OP_LINIT,
    OP_LSQ,
    OP_LCMP,
    OP_NPOW1,
    OP_NPOW2,
    OP_SPOW1,
    OP_SPOW2,
    OP_COEF,
    OP_MUL,
    OP_ACC,
    OP_DINIT,
    OP_DSTEP,
    OP_DEND,
    OP_EMIT,
    OP_SHIFT,
    OP_CLEAR
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_ECHO,
    S_DCLR,
    S_DSQ,
    S_DACC,
    S_LINIT,
    S_LSQ,
    S_LCMP,
    S_NP1,
    S_NP2,
    S_SP1,
    S_SP2,
    S_COEF,
    S_MUL,
    S_ACC,
    S_DINIT,
    S_DIV,
    S_DEND,
    S_EMIT,
    S_SEG2,
    S_FINISH
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] coord;
    logic [1:0] term;
    logic       use_third;
    logic       run_end;
    logic       path_end;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic search_done;
    logic s_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/cmr_point_if.sv
// input point channel
interface cmr_point_if #(
  parameter int COORD_BITS = cmr_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic                         last_point;

  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

>>> rtl/cmr_result_if.sv
// output point channel
interface cmr_result_if #(
  parameter int COORD_BITS = cmr_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic signed [COORD_BITS-1:0] out_z;
  logic                         run_end;
  logic                         path_end;
  logic                         steps_clipped;

  modport source (output valid, out_x, out_y, out_z, run_end, path_end, steps_clipped,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, run_end, path_end, steps_clipped,
                output ready);
endinterface

>>> rtl/cmr_cfg_if.sv
// step length configuration channel
interface cmr_cfg_if ();
  logic                                 valid;
  logic                                 ready;
  logic [cmr_pkg::STEP_LEN_BITS-1:0]    segment_step_length;

  modport source (output valid, segment_step_length, input ready);
  modport sink (input valid, segment_step_length, output ready);
endinterface

>>> rtl/cmr_dp.sv
// datapath: point history, step search, term accumulation, serial divider, output register
module cmr_dp #(
  parameter int COORD_BITS = cmr_pkg::COORD_BITS_DEF,
  parameter int MAX_STEPS  = cmr_pkg::MAX_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cmr_pkg::dp_cmd_t                    cmd_i,
  output cmr_pkg::dp_status_t                 status_o,
  input  logic signed [COORD_BITS-1:0]        point_x_i,
  input  logic signed [COORD_BITS-1:0]        point_y_i,
  input  logic signed [COORD_BITS-1:0]        point_z_i,
  input  logic                                last_point_i,
  input  logic                                cfg_valid_i,
  input  logic [cmr_pkg::STEP_LEN_BITS-1:0]   cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [COORD_BITS-1:0]        out_x_o,
  output logic signed [COORD_BITS-1:0]        out_y_o,
  output logic signed [COORD_BITS-1:0]        out_z_o,
  output logic                                run_end_o,
  output logic                                path_end_o,
  output logic                                steps_clipped_o
);
  import cmr_pkg::*;

  localparam int W   = COORD_BITS;
  localparam int SEG = seg_limit(MAX_STEPS);
  localparam int NB  = step_bits(MAX_STEPS);
  localparam int MFB = fac_bits(MAX_STEPS);
  localparam int CW  = W + 4;
  localparam int PW  = CW + MFB + 1;
  localparam int NW  = num_bits(COORD_BITS, MAX_STEPS);
  localparam int DW  = (W + 1 > DIST_LIMIT_BIT + 1) ? W + 1 : DIST_LIMIT_BIT + 1;
  localparam int LW  = STEP_LEN_BITS + NB;
  localparam int SQW = 2 * DIST_LIMIT_BIT;
  localparam int D2W = SQW + 2;
  localparam logic signed [NW:0] CMAX = {{(NW - W + 2){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [NW:0] CMIN = {{(NW - W + 2){1'b1}}, {(W - 1){1'b0}}};

  logic signed [W-1:0] cur_q [3];
  logic signed [W-1:0] third_q [3];
  logic signed [W-1:0] second_q [3];
  logic signed [W-1:0] prev_q [3];
  logic signed [W-1:0] g0_q [3];
  logic signed [W-1:0] g1_q [3];
  logic signed [W-1:0] g2_q [3];
  logic signed [W-1:0] g3_q [3];
  logic signed [W-1:0] res_q [3];
  logic                last_q;
  logic                curve_q;

  logic [STEP_LEN_BITS-1:0] step_len_q;
  logic [SQW-1:0]           sq_q;
  logic [D2W-1:0]           d2_q;
  logic                     huge_q;
  logic [LW-1:0]            len_q;
  logic [NB-1:0]            n_q;
  logic [NB-1:0]            s_q;
  logic                     clip_q;
  logic [MFB-1:0]           n2_q, n3_q, s2_q, s3_q, sn2_q, s2n_q;

  logic signed [CW-1:0] coef_q [4];
  logic signed [PW-1:0] prod_q;
  logic signed [NW-1:0] acc_q;
  logic [NW-1:0]        u_q;
  logic [MFB:0]         rem_q;
  logic                 neg_q;

  logic                 out_valid_q;
  logic signed [W-1:0]  out_q [3];
  logic                 run_end_q, path_end_q, clip_out_q;

  // distance of the segment end points on the selected coordinate
  logic [W:0]             diff;
  logic [W:0]             mag;
  logic [DW-1:0]          mag_e;
  logic                   big;
  logic [DIST_LIMIT_BIT-1:0] sq_in;
  logic                   fits;

  // term selection
  logic signed [CW-1:0] e0, e1, e2, e3;
  logic [MFB-1:0]       dvs, fac_u;
  logic signed [NW-1:0] bias;
  logic signed [MFB:0]  fac_s;
  logic signed [PW-1:0] prod_d;
  logic [NW-1:0]        acc_u, neg_mag;
  logic [MFB+1:0]       rem_t;
  logic                 rem_ge;
  logic signed [NW:0]   quo_s;
  logic signed [W-1:0]  sat_v;

  always_comb begin
    diff  = {g1_q[cmd_i.coord][W-1], g1_q[cmd_i.coord]}
          - {g2_q[cmd_i.coord][W-1], g2_q[cmd_i.coord]};
    mag   = diff[W] ? (~diff + (W+1)'(1)) : diff;
    mag_e = DW'(mag);
    big   = |mag_e[DW-1:DIST_LIMIT_BIT];
    sq_in = (cmd_i.op == OP_LSQ) ? DIST_LIMIT_BIT'(len_q) : mag_e[DIST_LIMIT_BIT-1:0];
    fits  = ({2'b00, sq_q} >= d2_q) && !huge_q;

    e0 = CW'(g0_q[cmd_i.coord]);
    e1 = CW'(g1_q[cmd_i.coord]);
    e2 = CW'(g2_q[cmd_i.coord]);
    e3 = CW'(g3_q[cmd_i.coord]);

    dvs  = curve_q ? MFB'({n3_q, 1'b0}) : MFB'({n_q, 1'b0});
    bias = curve_q ? NW'(n3_q) : NW'(n_q);

    unique case (cmd_i.term)
      2'd0:    fac_u = curve_q ? MFB'({n3_q, 1'b0}) : MFB'({n_q - s_q, 1'b0});
      2'd1:    fac_u = curve_q ? sn2_q : MFB'({s_q, 1'b0});
      2'd2:    fac_u = curve_q ? s2n_q : '0;
      default: fac_u = curve_q ? s3_q : '0;
    endcase
    fac_s  = $signed({1'b0, fac_u});
    prod_d = coef_q[cmd_i.term] * fac_s;

    acc_u   = acc_q;
    neg_mag = ~acc_u + NW'(1);

    rem_t  = {rem_q, u_q[NW-1]};
    rem_ge = rem_t >= (MFB+2)'(dvs);

    quo_s = neg_q ? -$signed({1'b0, u_q}) : $signed({1'b0, u_q});
    if (quo_s > CMAX) begin
      sat_v = {1'b0, {(W - 1){1'b1}}};
    end else if (quo_s < CMIN) begin
      sat_v = {1'b1, {(W - 1){1'b0}}};
    end else begin
      sat_v = W'(quo_s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_len_q  <= STEP_LEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        step_len_q <= cfg_data_i;
      end
      if (cmd_i.op == OP_EMIT || cmd_i.op == OP_ECHO) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_TAKE: begin
        cur_q[0] <= point_x_i;
        cur_q[1] <= point_y_i;
        cur_q[2] <= point_z_i;
        last_q   <= last_point_i;
      end
      OP_ECHO: begin
        out_q      <= cur_q;
        run_end_q  <= cmd_i.run_end;
        path_end_q <= cmd_i.path_end;
        clip_out_q <= 1'b0;
      end
      OP_SEG_LINE: begin
        g0_q    <= prev_q;
        g1_q    <= prev_q;
        g2_q    <= cur_q;
        g3_q    <= cur_q;
        curve_q <= 1'b0;
      end
      OP_SEG_A: begin
        g0_q    <= cmd_i.use_third ? third_q : second_q;
        g1_q    <= second_q;
        g2_q    <= prev_q;
        g3_q    <= cur_q;
        curve_q <= 1'b1;
      end
      OP_SEG_B: begin
        g0_q    <= second_q;
        g1_q    <= prev_q;
        g2_q    <= cur_q;
        g3_q    <= cur_q;
        curve_q <= 1'b1;
      end
      OP_DCLR: begin
        d2_q   <= '0;
        huge_q <= 1'b0;
      end
      OP_DSQ: begin
        sq_q   <= SQW'(sq_in) * SQW'(sq_in);
        huge_q <= huge_q | big;
      end
      OP_DACC: d2_q <= d2_q + D2W'(sq_q);
      OP_LINIT: begin
        len_q <= LW'(step_len_q);
        n_q   <= NB'(1);
      end
      OP_LSQ: sq_q <= SQW'(sq_in) * SQW'(sq_in);
      OP_LCMP: begin
        if (fits) begin
          clip_q <= 1'b0;
        end else if (n_q == NB'(SEG)) begin
          clip_q <= 1'b1;
        end else begin
          n_q   <= n_q + NB'(1);
          len_q <= len_q + LW'(step_len_q);
        end
      end
      OP_NPOW1: begin
        n2_q <= MFB'(n_q) * MFB'(n_q);
        s_q  <= NB'(1);
      end
      OP_NPOW2: n3_q <= n2_q * MFB'(n_q);
      OP_SPOW1: begin
        s2_q  <= MFB'(s_q) * MFB'(s_q);
        sn2_q <= MFB'(s_q) * n2_q;
      end
      OP_SPOW2: begin
        s3_q  <= s2_q * MFB'(s_q);
        s2n_q <= s2_q * MFB'(n_q);
      end
      OP_COEF: begin
        if (curve_q) begin
          coef_q[0] <= e1;
          coef_q[1] <= e2 - e0;
          coef_q[2] <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
          coef_q[3] <= (e1 <<< 1) + e1 - e0 - (e2 <<< 1) - e2 + e3;
        end else begin
          coef_q[0] <= e1;
          coef_q[1] <= e2;
          coef_q[2] <= '0;
          coef_q[3] <= '0;
        end
        acc_q  <= bias;
        prod_q <= '0;
      end
      OP_MUL: begin
        acc_q  <= acc_q + NW'(prod_q);
        prod_q <= prod_d;
      end
      OP_ACC: acc_q <= acc_q + NW'(prod_q);
      OP_DINIT: begin
        neg_q <= acc_q[NW-1];
        u_q   <= acc_q[NW-1] ? (neg_mag + NW'(dvs) - NW'(1)) : acc_u;
        rem_q <= '0;
      end
      OP_DSTEP: begin
        rem_q <= rem_ge ? (MFB+1)'(rem_t - (MFB+2)'(dvs)) : rem_t[MFB:0];
        u_q   <= {u_q[NW-2:0], rem_ge};
      end
      OP_DEND: res_q[cmd_i.coord] <= sat_v;
      OP_EMIT: begin
        out_q      <= res_q;
        run_end_q  <= cmd_i.run_end;
        path_end_q <= cmd_i.path_end;
        clip_out_q <= clip_q;
        s_q        <= s_q + NB'(1);
      end
      OP_SHIFT: begin
        third_q  <= second_q;
        second_q <= prev_q;
        prev_q   <= cur_q;
      end
      OP_CLEAR: begin
        for (int i = 0; i < 3; i++) begin
          third_q[i]  <= '0;
          second_q[i] <= '0;
          prev_q[i]   <= '0;
        end
      end
      default: ;
    endcase
  end

  assign status_o.last        = last_q;
  assign status_o.search_done = fits || (n_q == NB'(SEG));
  assign status_o.s_last      = (s_q == n_q);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_x_o         = out_q[0];
  assign out_y_o         = out_q[1];
  assign out_z_o         = out_q[2];
  assign run_end_o       = run_end_q;
  assign path_end_o      = path_end_q;
  assign steps_clipped_o = clip_out_q;

  // remainder stays below the divisor through the serial division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.op) == OP_DSTEP |-> rem_q < (MFB+1)'(dvs))
    else $error("divider remainder out of range");

  // step count never leaves its range once the search has started
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.op) == OP_LCMP |-> (n_q != '0) && (n_q <= NB'(SEG)))
    else $error("step count out of range");

  // a new result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EMIT || cmd_i.op == OP_ECHO) |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transfer");

endmodule

>>> rtl/cmr_ctrl.sv
// controller: sequences segments, steps, coordinates and the divider
module cmr_ctrl #(
  parameter int COORD_BITS = cmr_pkg::COORD_BITS_DEF,
  parameter int MAX_STEPS  = cmr_pkg::MAX_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output cmr_pkg::dp_cmd_t    cmd_o,
  input  cmr_pkg::dp_status_t status_i
);
  import cmr_pkg::*;

  localparam int NW = num_bits(COORD_BITS, MAX_STEPS);
  localparam int CB = $clog2(NW);

  ctrl_state_e state_q, state_d;
  logic [1:0]  ps_q, ps_d;
  logic [1:0]  coord_q, coord_d;
  logic [1:0]  term_q, term_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic        seg2_q, seg2_d;
  logic        final_seg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ps_q    <= '0;
      coord_q <= '0;
      term_q  <= '0;
      cnt_q   <= '0;
      seg2_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ps_q    <= ps_d;
      coord_q <= coord_d;
      term_q  <= term_d;
      cnt_q   <= cnt_d;
      seg2_q  <= seg2_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    ps_d      = ps_q;
    coord_d   = coord_q;
    term_d    = term_q;
    cnt_d     = cnt_q;
    seg2_d    = seg2_q;
    in_ready_o = 1'b0;
    cmd_o           = '0;
    cmd_o.op        = OP_NONE;
    cmd_o.coord     = coord_q;
    cmd_o.term      = term_q;
    final_seg = !(status_i.last && (ps_q >= 2'd2) && !seg2_q);

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_TAKE;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (ps_q == 2'd0) begin
          state_d = S_ECHO;
        end else if (ps_q == 2'd1) begin
          if (status_i.last) begin
            cmd_o.op = OP_SEG_LINE;
            state_d  = S_DCLR;
          end else begin
            state_d = S_FINISH;
          end
        end else begin
          cmd_o.op        = OP_SEG_A;
          cmd_o.use_third = (ps_q == 2'd3);
          state_d         = S_DCLR;
        end
      end
      S_ECHO: begin
        if (status_i.out_free) begin
          cmd_o.op       = OP_ECHO;
          cmd_o.run_end  = 1'b1;
          cmd_o.path_end = status_i.last;
          state_d        = S_FINISH;
        end
      end
      S_DCLR: begin
        cmd_o.op = OP_DCLR;
        coord_d  = '0;
        state_d  = S_DSQ;
      end
      S_DSQ: begin
        cmd_o.op = OP_DSQ;
        state_d  = S_DACC;
      end
      S_DACC: begin
        cmd_o.op = OP_DACC;
        if (coord_q == 2'd2) begin
          state_d = S_LINIT;
        end else begin
          coord_d = coord_q + 2'd1;
          state_d = S_DSQ;
        end
      end
      S_LINIT: begin
        cmd_o.op = OP_LINIT;
        state_d  = S_LSQ;
      end
      S_LSQ: begin
        cmd_o.op = OP_LSQ;
        state_d  = S_LCMP;
      end
      S_LCMP: begin
        cmd_o.op = OP_LCMP;
        state_d  = status_i.search_done ? S_NP1 : S_LSQ;
      end
      S_NP1: begin
        cmd_o.op = OP_NPOW1;
        state_d  = S_NP2;
      end
      S_NP2: begin
        cmd_o.op = OP_NPOW2;
        state_d  = S_SP1;
      end
      S_SP1: begin
        cmd_o.op = OP_SPOW1;
        state_d  = S_SP2;
      end
      S_SP2: begin
        cmd_o.op = OP_SPOW2;
        coord_d  = '0;
        state_d  = S_COEF;
      end
      S_COEF: begin
        cmd_o.op = OP_COEF;
        term_d   = '0;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        if (term_q == 2'd3) begin
          state_d = S_ACC;
        end else begin
          term_d = term_q + 2'd1;
        end
      end
      S_ACC: begin
        cmd_o.op = OP_ACC;
        state_d  = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.op = OP_DINIT;
        cnt_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DSTEP;
        if (cnt_q == CB'(NW - 1)) begin
          state_d = S_DEND;
        end else begin
          cnt_d = cnt_q + CB'(1);
        end
      end
      S_DEND: begin
        cmd_o.op = OP_DEND;
        if (coord_q == 2'd2) begin
          state_d = S_EMIT;
        end else begin
          coord_d = coord_q + 2'd1;
          state_d = S_COEF;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op       = OP_EMIT;
          cmd_o.run_end  = status_i.s_last && final_seg;
          cmd_o.path_end = status_i.s_last && final_seg && status_i.last;
          if (!status_i.s_last) begin
            state_d = S_SP1;
          end else if (final_seg) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_SEG2;
          end
        end
      end
      S_SEG2: begin
        cmd_o.op = OP_SEG_B;
        seg2_d   = 1'b1;
        state_d  = S_DCLR;
      end
      S_FINISH: begin
        seg2_d = 1'b0;
        if (status_i.last) begin
          cmd_o.op = OP_CLEAR;
          ps_d     = '0;
        end else begin
          cmd_o.op = OP_SHIFT;
          if (ps_q != 2'd3) begin
            ps_d = ps_q + 2'd1;
          end
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // a path ends with the point history emptied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && status_i.last) |=> (ps_q == 2'd0))
    else $error("path end did not clear the point count");

  // the second segment only follows a last point with curve history
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg2_q |-> (status_i.last && ps_q >= 2'd2))
    else $error("closing segment without a last point");

  // an accepted point always starts dispatch next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DISPATCH))
    else $error("accepted point not dispatched");

endmodule

>>> rtl/catmull_rom_path_subdivider_top.sv
// top level of the catmull-rom path subdivider
//
// point_i takes path points (signed fixed point) with last_point on the final one;
// a transfer happens when valid and ready are both high. result_o returns the
// subdivided path, run_end on the last result of each point, path_end on the last
// point of the path. cfg_i writes the step length and is always ready; write it
// only while the block is idle.
// the first point of a path is echoed; a second point that is not last gives no
// result; later points give the curve segment two points back, and the last point
// also the closing segment (a two point path gives a straight segment).
// the segment length search tries step counts n = 1, 2, ... in turn; each result point
// is worked out coordinate by coordinate with a numerator of NW bits (46 at 24 bit
// coordinates), divided by the bit-serial divider, one quotient bit a cycle.
// one point is worked on at a time; the next is taken once its last result sits in
// the output register, which holds it while the receiver stalls, and the block
// stops at the next result until the register is free.
// reset clears the point history and sets the step length to 1024 coordinate units.
module catmull_rom_path_subdivider_top #(
  parameter int COORD_BITS = cmr_pkg::COORD_BITS_DEF,
  parameter int MAX_STEPS  = cmr_pkg::MAX_STEPS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cmr_point_if.sink    point_i,
  cmr_result_if.source result_o,
  cmr_cfg_if.sink      cfg_i
);
  import cmr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_i.ready = 1'b1;

  cmr_ctrl #(
    .COORD_BITS(COORD_BITS),
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(point_i.valid),
    .in_ready_o(point_i.ready),
    .cmd_o     (cmd),
    .status_i  (status)
  );

  cmr_dp #(
    .COORD_BITS(COORD_BITS),
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .point_x_i      (point_i.point_x),
    .point_y_i      (point_i.point_y),
    .point_z_i      (point_i.point_z),
    .last_point_i   (point_i.last_point),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_data_i     (cfg_i.segment_step_length),
    .out_valid_o    (result_o.valid),
    .out_ready_i    (result_o.ready),
    .out_x_o        (result_o.out_x),
    .out_y_o        (result_o.out_y),
    .out_z_o        (result_o.out_z),
    .run_end_o      (result_o.run_end),
    .path_end_o     (result_o.path_end),
    .steps_clipped_o(result_o.steps_clipped)
  );

endmodule
